// ===== rtl/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types and constants of the line follower PID drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int GAIN_W    = 24;
    localparam int SPEED_W   = 7;
    localparam int ACC_W     = 48;
    localparam int FRAC_W    = 16;
    localparam int ERR_W     = 14;
    localparam int POS_W     = 13;
    localparam int CMP_W     = 10;
    localparam int SUM_W     = 16;
    localparam int LIT_W     = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_R     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEFT  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RIGHT = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEFT   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RIGHT  = 8'd7;

    localparam int SENSOR_STEP = 1000;
    localparam int CENTER_POS  = 4500;
    localparam int IDLE_LIMIT  = 25;
    localparam int COMPARE_MAX = 1000;

    localparam logic signed [ACC_W-1:0] TURN_FAST = 48'sd100;
    localparam logic signed [ACC_W-1:0] TURN_BACK = -48'sd20;
    localparam logic signed [ACC_W-1:0] SLOW_FAST = 48'sd70;
    localparam logic signed [ACC_W-1:0] SLOW_BACK = -48'sd53;

    typedef struct packed {
        logic start;
        logic clr;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        PH_P = 2'd0,
        PH_I = 2'd1,
        PH_D = 2'd2,
        PH_R = 2'd3
    } t_phase;

    // divide by 2^16, rounding toward zero
    function automatic logic signed [ACC_W-1:0] f_trunc16(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] t;
        t = x[ACC_W-1] ? (x + $signed(ACC_W'((1 << FRAC_W) - 1))) : x;
        return t >>> FRAC_W;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_ext_speed(input logic [SPEED_W-1:0] v);
        return $signed({{(ACC_W-SPEED_W){1'b0}}, v});
    endfunction

endpackage

// ===== rtl/lfpd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_div
// Restoring divider, one quotient bit per cycle: weight sum over lit count.
// ----------------------------------------------------------------------------
module lfpd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lfpd_pkg::SUM_W-1:0]   i_dividend,
    input  logic [lfpd_pkg::LIT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [lfpd_pkg::POS_W-1:0]   o_quot
);
    import lfpd_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_q;
    logic [LIT_W-1:0] r_rem, r_div;
    logic [LIT_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? LIT_W'(w_trial - {1'b0, r_div}) : w_trial[LIT_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[POS_W-1:0];

endmodule

// ===== rtl/lfpd_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_mac
// Bit-serial multiply-accumulate: one gain bit per cycle, signed multiplicand.
// ----------------------------------------------------------------------------
module lfpd_mac #(
    parameter int MW = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfpd_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [MW-1:0]                i_mcand,
    input  logic [lfpd_pkg::GAIN_W-1:0]         i_gain,
    output logic                                o_done,
    output logic signed [lfpd_pkg::ACC_W-1:0]   o_acc
);
    import lfpd_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic                    r_busy, r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_mc, r_acc;
    logic [GAIN_W-1:0]       r_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mc <= ACC_W'(i_mcand);
            r_g  <= i_gain;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_g[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc <<< 1;
            r_g  <= r_g >> 1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/line_follower_pid_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_pid_drive
// PID motor drive from 8-sensor line snapshots, bit-serial divide and MACs.
// Per beat: divide (skipped with no sensor lit), history update and sum, then
//   four serial products (P, I, D, R) on one MAC, which dominate; then mix and clamp.
// A new beat is taken only once the last one has left the output state;
//   a new beat is taken while a result waits, the next result stalls until it goes.
// Reset (synchronous, active low): registers to defaults, history cleared,
//   held position 4500, side memory and idle count zero.
// ----------------------------------------------------------------------------
module line_follower_pid_drive #(
    parameter int HISTORY_LEN   = 5,
    parameter int COMPARE_SCALE = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // sensor_bits
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // left_forward[9:0] left_reverse[19:10] right_forward[29:20]
    // right_reverse[39:30] line_position[52:40] lit_count[56:53] zero pad
    output logic [63:0]                       m_axis_tdata,
    output logic                              m_axis_tuser,  // line_lost
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfpd_pkg::GAIN_W-1:0]       i_cfg_data
);
    import lfpd_pkg::*;

    localparam int SW    = ERR_W + $clog2(HISTORY_LEN + 1);
    localparam int MW    = SW + 1;
    localparam int HIW   = $clog2(HISTORY_LEN + 1);
    localparam int PW    = $clog2(COMPARE_MAX * COMPARE_SCALE + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIV  = 10'b0000000010,
        S_POS  = 10'b0000000100,
        S_SUM  = 10'b0000001000,
        S_MST  = 10'b0000010000,
        S_MWT  = 10'b0000100000,
        S_MTR  = 10'b0001000000,
        S_XSP  = 10'b0010000000,
        S_CLP  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    function automatic logic [CMP_W-1:0] f_cmp(input logic signed [ACC_W-1:0] s);
        logic [ACC_W-1:0] mag;
        logic [PW-1:0]    p;
        mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
        p   = PW'(mag[CMP_W-1:0]) * PW'(COMPARE_SCALE);
        if (mag >= ACC_W'(COMPARE_MAX)) begin
            return CMP_W'(COMPARE_MAX);
        end else if (p > PW'(COMPARE_MAX)) begin
            return CMP_W'(COMPARE_MAX);
        end else begin
            return p[CMP_W-1:0];
        end
    endfunction

    t_state r_state;
    t_phase r_ph;

    logic [GAIN_W-1:0]  r_gp, r_gi, r_gd, r_gr;
    logic [SPEED_W-1:0] r_bl, r_br, r_ml, r_mr;

    logic signed [ERR_W-1:0] r_hist [HISTORY_LEN:0];
    logic [POS_W-1:0]        r_held, r_pos;
    logic                    r_side;
    logic [7:0]              r_idle;
    logic [LIT_W-1:0]        r_lit;
    logic [HIW-1:0]          r_cnt;

    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W:0]   r_d;
    logic signed [SW-1:0]    r_isum;
    logic [SW-1:0]           r_rsum;
    logic signed [ACC_W-1:0] r_pid, r_rp, r_m, r_xl, r_xr, r_sl, r_sr;

    logic                    r_ov;
    logic [63:0]             r_odata;
    logic                    r_olost;

    logic [SUM_W-1:0]        w_sum;
    logic [LIT_W-1:0]        w_lit;
    logic                    w_acc;
    logic                    w_div_done;
    logic [POS_W-1:0]        w_quot;
    t_mac_ctl                w_ctl;
    logic signed [MW-1:0]    w_mcand;
    logic [GAIN_W-1:0]       w_gain;
    logic                    w_mac_done;
    logic signed [ACC_W-1:0] w_mac_acc;
    logic signed [ERR_W-1:0] w_err, w_e;
    logic signed [SW-1:0]    w_e_ext;
    logic signed [ACC_W-1:0] w_tl, w_tr, w_cl, w_cr;
    logic                    w_lost;
    logic                    w_out_free;

    assign w_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_ov || m_axis_tready;
    assign w_lost        = (r_lit == '0);

    always_comb begin
        w_sum = '0;
        w_lit = '0;
        for (int k = 0; k < 8; k++) begin
            if (s_axis_tdata[k]) begin
                w_sum = w_sum + SUM_W'(SENSOR_STEP * (k + 1));
                w_lit = w_lit + 1'b1;
            end
        end
    end

    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && (w_lit != '0)),
        .i_dividend (w_sum),
        .i_divisor  (w_lit),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_ctl.start = (r_state == S_MST);
        w_ctl.clr   = (r_ph == PH_P) || (r_ph == PH_R);
        unique case (r_ph)
            PH_P: begin
                w_mcand = MW'(r_err);
                w_gain  = r_gp;
            end
            PH_I: begin
                w_mcand = MW'(r_isum);
                w_gain  = r_gi;
            end
            PH_D: begin
                w_mcand = MW'(r_d);
                w_gain  = r_gd;
            end
            PH_R: begin
                w_mcand = $signed({1'b0, r_rsum});
                w_gain  = r_gr;
            end
            default: begin
                w_mcand = '0;
                w_gain  = '0;
            end
        endcase
    end

    lfpd_mac #(.MW(MW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mcand (w_mcand),
        .i_gain  (w_gain),
        .o_done  (w_mac_done),
        .o_acc   (w_mac_acc)
    );

    assign w_err   = $signed(ERR_W'(CENTER_POS)) - $signed({1'b0, r_pos});
    assign w_e     = r_hist[r_cnt];
    assign w_e_ext = SW'(w_e);

    always_comb begin
        w_tl = f_trunc16(r_xl);
        w_tr = f_trunc16(r_xr);
        w_cl = (w_tl > f_ext_speed(r_ml)) ? f_ext_speed(r_ml) : w_tl;
        w_cr = (w_tr > f_ext_speed(r_mr)) ? f_ext_speed(r_mr) : w_tr;
        if (w_lost) begin
            if (r_idle < 8'(IDLE_LIMIT)) begin
                w_cl = r_side ? TURN_FAST : TURN_BACK;
                w_cr = r_side ? TURN_BACK : TURN_FAST;
            end else begin
                w_cl = r_side ? SLOW_FAST : SLOW_BACK;
                w_cr = r_side ? SLOW_BACK : SLOW_FAST;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp <= 24'd131;
            r_gi <= 24'd66;
            r_gd <= 24'd983040;
            r_gr <= 24'd0;
            r_bl <= 7'd92;
            r_br <= 7'd92;
            r_ml <= 7'd100;
            r_mr <= 7'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_P:     r_gp <= i_cfg_data;
                REG_GAIN_I:     r_gi <= i_cfg_data;
                REG_GAIN_D:     r_gd <= i_cfg_data;
                REG_GAIN_R:     r_gr <= i_cfg_data;
                REG_BASE_LEFT:  r_bl <= i_cfg_data[SPEED_W-1:0];
                REG_BASE_RIGHT: r_br <= i_cfg_data[SPEED_W-1:0];
                REG_MAX_LEFT:   r_ml <= i_cfg_data[SPEED_W-1:0];
                REG_MAX_RIGHT:  r_mr <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_P;
            r_held  <= POS_W'(CENTER_POS);
            r_side  <= 1'b0;
            r_idle  <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k <= HISTORY_LEN; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_lit <= w_lit;
                        if (s_axis_tdata[0]) r_side <= 1'b1;
                        if (s_axis_tdata[7]) r_side <= 1'b0;
                        if (w_lit == '0) begin
                            r_pos   <= r_held;
                            r_state <= S_POS;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pos   <= w_quot;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    if (w_lost) begin
                        if (r_idle != 8'hFF) r_idle <= r_idle + 1'b1;
                    end else begin
                        r_held <= r_pos;
                        r_idle <= '0;
                    end
                    for (int k = HISTORY_LEN; k > 0; k--) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                    r_hist[0] <= w_err;
                    r_err     <= w_err;
                    r_d       <= (ERR_W+1)'(w_err) - (ERR_W+1)'(r_hist[0]);
                    r_isum    <= '0;
                    r_rsum    <= '0;
                    r_cnt     <= '0;
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    r_isum <= r_isum + w_e_ext;
                    r_rsum <= r_rsum + (w_e_ext[SW-1] ? SW'(-w_e_ext) : SW'(w_e_ext));
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == HIW'(HISTORY_LEN - 1)) begin
                        r_ph    <= PH_P;
                        r_state <= S_MST;
                    end
                end
                S_MST: begin
                    r_state <= S_MWT;
                end
                S_MWT: begin
                    if (w_mac_done) begin
                        unique case (r_ph)
                            PH_P: begin
                                r_ph    <= PH_I;
                                r_state <= S_MST;
                            end
                            PH_I: begin
                                r_ph    <= PH_D;
                                r_state <= S_MST;
                            end
                            PH_D: begin
                                r_pid   <= w_mac_acc;
                                r_ph    <= PH_R;
                                r_state <= S_MST;
                            end
                            PH_R: begin
                                r_rp    <= w_mac_acc;
                                r_state <= S_MTR;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MTR: begin
                    r_m     <= f_trunc16(r_pid);
                    r_state <= S_XSP;
                end
                S_XSP: begin
                    r_xl    <= ((f_ext_speed(r_bl) + r_m) <<< FRAC_W) - r_rp;
                    r_xr    <= ((f_ext_speed(r_br) - r_m) <<< FRAC_W) - r_rp;
                    r_state <= S_CLP;
                end
                S_CLP: begin
                    r_sl    <= w_cl;
                    r_sr    <= w_cr;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_odata <= {7'd0, r_lit, r_pos,
                                    r_sr[ACC_W-1] ? f_cmp(r_sr) : CMP_W'(0),
                                    r_sr[ACC_W-1] ? CMP_W'(0) : f_cmp(r_sr),
                                    r_sl[ACC_W-1] ? f_cmp(r_sl) : CMP_W'(0),
                                    r_sl[ACC_W-1] ? CMP_W'(0) : f_cmp(r_sl)};
                        r_olost <= w_lost;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_olost;

endmodule
